// ----- rtl/blr_pkg.sv -----
// Shared types and constants of the Bresenham line rasterizer.
package blr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int DELTA_BITS  = COORD_BITS + 1;
  localparam int ACC_BITS    = COORD_BITS + 1;
  localparam int HEIGHT_BITS = 16;
  localparam int COLOR_BITS  = 24;

  // At most this many pixels leave the block for one accepted item.
  localparam int BURST_MAX   = 64;
  localparam int BURST_BITS  = $clog2(BURST_MAX);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAISED_COLOR = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FLAT_COLOR   = CFG_IDX_BITS'(1);

  localparam logic [COLOR_BITS-1:0] RAISED_COLOR_RST = 24'hFF0000;
  localparam logic [COLOR_BITS-1:0] FLAT_COLOR_RST   = 24'h00FF00;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [HEIGHT_BITS-1:0] start_height;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic signed [HEIGHT_BITS-1:0] end_height;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         last_pixel;
  } out_item_t;

  // A classified line, as handed from the front end to the walker.
  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] major_delta;
    logic [COORD_BITS-1:0] minor_delta;
    logic                  dir_x_neg;
    logic                  dir_y_neg;
    logic                  x_is_major;
    logic [COLOR_BITS-1:0] color;
  } line_desc_t;

endpackage

// ----- rtl/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer: front end, line queue and walker.
// First pixel path: front-end register, line queue, walker run_r, walker output register.
// Throughput: one pixel per cycle while out_ready allows, from the walker's single
// accumulator step; an item occupies it for its load and then up to 64 pixels, and a line
// longer than 64 pixels needs one further item per additional 64 pixels.
// Reset (synchronous, rst_n low) empties all stages; colors return to red and green.
module bresenham_line_rasterizer import blr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_item,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COLOR_BITS-1:0]   cfg_data
);

  logic       front_valid, front_ready;
  line_desc_t front_desc;
  logic       queue_valid, queue_ready;
  line_desc_t queue_desc;

  blr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .desc_valid (front_valid),
    .desc_ready (front_ready),
    .desc       (front_desc)
  );

  blr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_desc),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_desc)
  );

  blr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (queue_valid),
    .desc_ready (queue_ready),
    .desc       (queue_desc),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ----- rtl/blr_front.sv -----
// Front end: takes line items, holds the color registers and classifies each line.
module blr_front import blr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_item,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COLOR_BITS-1:0]   cfg_data,
  output logic                    desc_valid,
  input  logic                    desc_ready,
  output line_desc_t              desc
);

  logic [COLOR_BITS-1:0] raised_color_r;
  logic [COLOR_BITS-1:0] flat_color_r;

  logic                         valid_r;
  logic [COORD_BITS-1:0]        sx_r, sy_r;
  logic signed [DELTA_BITS-1:0] dx_r, dy_r;
  logic [COLOR_BITS-1:0]        color_r;

  logic                         in_fire;
  logic signed [DELTA_BITS-1:0] dx_nxt, dy_nxt;
  logic [DELTA_BITS-1:0]        adx_full, ady_full;
  logic [COORD_BITS-1:0]        adx, ady;
  logic                         x_major;

  assign cfg_ready = 1'b1;
  assign in_ready  = !valid_r || desc_ready;
  assign in_fire   = in_valid && in_ready;

  assign dx_nxt = {in_item.end_x[COORD_BITS-1], in_item.end_x}
                - {in_item.start_x[COORD_BITS-1], in_item.start_x};
  assign dy_nxt = {in_item.end_y[COORD_BITS-1], in_item.end_y}
                - {in_item.start_y[COORD_BITS-1], in_item.start_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raised_color_r <= RAISED_COLOR_RST;
      flat_color_r   <= FLAT_COLOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RAISED_COLOR: raised_color_r <= cfg_data;
        REG_FLAT_COLOR:   flat_color_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sx_r    <= in_item.start_x;
      sy_r    <= in_item.start_y;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      color_r <= (in_item.start_height != '0 || in_item.end_height != '0)
                 ? raised_color_r : flat_color_r;
    end
  end

  // The magnitude of a difference of two coordinates always fits in COORD_BITS.
  assign adx_full = dx_r[DELTA_BITS-1] ? DELTA_BITS'(~dx_r + 1'b1) : dx_r;
  assign ady_full = dy_r[DELTA_BITS-1] ? DELTA_BITS'(~dy_r + 1'b1) : dy_r;
  assign adx      = adx_full[COORD_BITS-1:0];
  assign ady      = ady_full[COORD_BITS-1:0];
  assign x_major  = adx > ady;

  always_comb begin
    desc.start_x     = sx_r;
    desc.start_y     = sy_r;
    desc.x_is_major  = x_major;
    desc.major_delta = x_major ? adx : ady;
    desc.minor_delta = x_major ? ady : adx;
    // A zero delta counts as the negative direction; that axis never moves.
    desc.dir_x_neg   = dx_r[DELTA_BITS-1] || (dx_r == '0);
    desc.dir_y_neg   = dy_r[DELTA_BITS-1] || (dy_r == '0);
    desc.color       = color_r;
  end

  assign desc_valid = valid_r;

endmodule

// ----- rtl/blr_queue.sv -----
// Short queue of classified lines between the front end and the walker.
module blr_queue import blr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  line_desc_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output line_desc_t pop_data
);

  line_desc_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0]   count_r;
  logic                   push, pop;

  assign push_ready = count_r != QCNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/blr_back.sv -----
// Walker: steps the Bresenham accumulator and emits one pixel per cycle while a burst runs and out_ready allows.
module blr_back import blr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       desc_valid,
  output logic       desc_ready,
  input  line_desc_t desc,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  logic                  busy_r;
  logic                  run_r;
  logic [BURST_BITS-1:0] burst_r;
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic [ACC_BITS-1:0]   err_r;
  logic [COORD_BITS-1:0] steps_r;
  logic [COORD_BITS-1:0] major_r, minor_r;
  logic                  dir_x_neg_r, dir_y_neg_r, x_major_r;
  logic [COLOR_BITS-1:0] color_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic                  pop, step;
  logic [ACC_BITS-1:0]   acc_sum;
  logic [ACC_BITS:0]     acc_diff;
  logic                  minor_step;
  logic [ACC_BITS-1:0]   err_nxt;
  logic [COORD_BITS-1:0] x_moved, y_moved, cur_x_nxt, cur_y_nxt;
  logic [COORD_BITS-1:0] steps_nxt;
  logic                  line_done, burst_end;

  // An item taken while a line is still open only releases its next burst.
  assign desc_ready = !run_r;
  assign pop        = desc_valid && desc_ready;
  assign step       = run_r && (!out_valid_r || out_ready);

  always_comb begin
    acc_sum    = err_r + ACC_BITS'(minor_r);
    acc_diff   = {1'b0, acc_sum} - (ACC_BITS + 1)'(major_r);
    minor_step = !acc_diff[ACC_BITS];
    err_nxt    = minor_step ? acc_diff[ACC_BITS-1:0] : acc_sum;
    x_moved    = dir_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    y_moved    = dir_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    cur_x_nxt  = (x_major_r || minor_step) ? x_moved : cur_x_r;
    cur_y_nxt  = (!x_major_r || minor_step) ? y_moved : cur_y_r;
    steps_nxt  = steps_r + 1'b1;
    line_done  = steps_nxt == major_r;
    burst_end  = burst_r == BURST_BITS'(BURST_MAX - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      run_r       <= 1'b0;
      burst_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        burst_r <= '0;
        if (busy_r) begin
          run_r <= 1'b1;
        end else begin
          busy_r <= desc.major_delta != '0;
          run_r  <= desc.major_delta != '0;
        end
      end else if (step) begin
        burst_r <= burst_r + 1'b1;
        if (line_done) begin
          busy_r <= 1'b0;
          run_r  <= 1'b0;
        end else if (burst_end) begin
          run_r <= 1'b0;
        end
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !busy_r) begin
      cur_x_r     <= desc.start_x;
      cur_y_r     <= desc.start_y;
      err_r       <= ACC_BITS'(desc.major_delta >> 1);
      steps_r     <= '0;
      major_r     <= desc.major_delta;
      minor_r     <= desc.minor_delta;
      dir_x_neg_r <= desc.dir_x_neg;
      dir_y_neg_r <= desc.dir_y_neg;
      x_major_r   <= desc.x_is_major;
      color_r     <= desc.color;
    end else if (step) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
      steps_r <= steps_nxt;
    end
    if (step) begin
      out_item_r.pixel_x     <= cur_x_nxt;
      out_item_r.pixel_y     <= cur_y_nxt;
      out_item_r.pixel_color <= color_r;
      out_item_r.last_pixel  <= line_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_run_within_line: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> busy_r)
    else $error("walker emitting without an open line");

  a_steps_below_major: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> steps_r < major_r)
    else $error("step count ran past the major delta");

  a_err_below_major: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> err_r < ACC_BITS'(major_r))
    else $error("error accumulator not reduced below the major delta");

  a_burst_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (step && burst_end) |=> !run_r)
    else $error("more pixels than one burst for a single item");

endmodule
